FILE: design/owbm_pkg.sv
`timescale 1ns / 1ps
// Package for the one-wire bus master: widths, codes, beat and config types.
// Used by the interfaces, the config block, the sequencer core and the top level.
package owbm_pkg;

    localparam int TICK_COUNT_WIDTH = 10;
    localparam int BITS_PER_BYTE    = 8;
    localparam int CFG_COUNT        = 8;
    localparam int CFG_W            = 10;
    localparam int CNT_W            = TICK_COUNT_WIDTH;
    localparam int CMP_W            = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BIT_IDX_W        = $clog2(BITS_PER_BYTE);
    localparam int REG_IDX_W        = $clog2(CFG_COUNT);
    localparam int ADDR_W           = REG_IDX_W + 2;
    localparam int APB_DATA_W       = 32;

    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << CNT_W) - 64'd1);

    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_WRITE_LEAD    = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD    = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_READ_LEAD     = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = REG_IDX_W'(7);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LEAD,
        PH_WR_HOLD,
        PH_RD_LEAD,
        PH_RD_WAIT,
        PH_RD_TAIL
    } t_phase;

    typedef struct packed {
        logic       command_valid;
        logic [1:0] operation;
        logic [7:0] write_data;
        logic       line_level;
    } t_cmd_beat;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       presence_level;
    } t_res_beat;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_tail_ticks;
        logic [CFG_W-1:0] write_lead_ticks;
        logic [CFG_W-1:0] write_hold_ticks;
        logic [CFG_W-1:0] read_lead_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] read_tail_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_ticks:     CFG_W'(500),
        presence_wait_ticks: CFG_W'(70),
        reset_tail_ticks:    CFG_W'(500),
        write_lead_ticks:    CFG_W'(10),
        write_hold_ticks:    CFG_W'(50),
        read_lead_ticks:     CFG_W'(5),
        read_sample_ticks:   CFG_W'(5),
        read_tail_ticks:     CFG_W'(50)
    };

    // Length of a phase in ticks: zero acts as one, clamp to the counter range.
    function automatic logic [CNT_W-1:0] phase_length(input t_phase ph, input t_cfg cfg);
        logic [CFG_W-1:0] raw;
        logic [CMP_W-1:0] ext;
        case (ph)
            PH_RST_LOW:  raw = cfg.reset_low_ticks;
            PH_RST_WAIT: raw = cfg.presence_wait_ticks;
            PH_RST_TAIL: raw = cfg.reset_tail_ticks;
            PH_WR_LEAD:  raw = cfg.write_lead_ticks;
            PH_WR_HOLD:  raw = cfg.write_hold_ticks;
            PH_RD_LEAD:  raw = cfg.read_lead_ticks;
            PH_RD_WAIT:  raw = cfg.read_sample_ticks;
            PH_RD_TAIL:  raw = cfg.read_tail_ticks;
            default:     raw = CFG_W'(1);
        endcase
        ext = CMP_W'(raw);
        if (ext == '0) begin
            ext = CMP_W'(1);
        end
        if (ext > COUNT_MAX) begin
            ext = COUNT_MAX;
        end
        return CNT_W'(ext);
    endfunction

endpackage

FILE: design/owbm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// Depends on owbm_pkg for the payload structs.
interface owbm_cmd_if;
    logic                valid;
    logic                ready;
    owbm_pkg::t_cmd_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface owbm_res_if;
    logic                valid;
    logic                ready;
    owbm_pkg::t_res_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/owbm_cfg.sv
`timescale 1ns / 1ps
// APB-style register file holding the eight slot timing registers.
// Depends on owbm_pkg for the register layout, indexes and reset values.
module owbm_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0]        paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output owbm_pkg::t_cfg                     o_cfg
);

    owbm_pkg::t_cfg                          r_cfg;
    logic [owbm_pkg::REG_IDX_W-1:0]          w_idx;
    logic [owbm_pkg::CFG_W-1:0]              w_rd;
    logic [owbm_pkg::CFG_W-1:0]              w_wd;

    assign w_idx  = paddr[owbm_pkg::ADDR_W-1:2];
    assign w_wd   = pwdata[owbm_pkg::CFG_W-1:0];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owbm_pkg::CFG_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                owbm_pkg::REG_RESET_LOW:     r_cfg.reset_low_ticks     <= w_wd;
                owbm_pkg::REG_PRESENCE_WAIT: r_cfg.presence_wait_ticks <= w_wd;
                owbm_pkg::REG_RESET_TAIL:    r_cfg.reset_tail_ticks    <= w_wd;
                owbm_pkg::REG_WRITE_LEAD:    r_cfg.write_lead_ticks    <= w_wd;
                owbm_pkg::REG_WRITE_HOLD:    r_cfg.write_hold_ticks    <= w_wd;
                owbm_pkg::REG_READ_LEAD:     r_cfg.read_lead_ticks     <= w_wd;
                owbm_pkg::REG_READ_SAMPLE:   r_cfg.read_sample_ticks   <= w_wd;
                owbm_pkg::REG_READ_TAIL:     r_cfg.read_tail_ticks     <= w_wd;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            owbm_pkg::REG_RESET_LOW:     w_rd = r_cfg.reset_low_ticks;
            owbm_pkg::REG_PRESENCE_WAIT: w_rd = r_cfg.presence_wait_ticks;
            owbm_pkg::REG_RESET_TAIL:    w_rd = r_cfg.reset_tail_ticks;
            owbm_pkg::REG_WRITE_LEAD:    w_rd = r_cfg.write_lead_ticks;
            owbm_pkg::REG_WRITE_HOLD:    w_rd = r_cfg.write_hold_ticks;
            owbm_pkg::REG_READ_LEAD:     w_rd = r_cfg.read_lead_ticks;
            owbm_pkg::REG_READ_SAMPLE:   w_rd = r_cfg.read_sample_ticks;
            owbm_pkg::REG_READ_TAIL:     w_rd = r_cfg.read_tail_ticks;
            default:                     w_rd = '0;
        endcase
    end

    assign prdata = owbm_pkg::APB_DATA_W'(w_rd);

endmodule

FILE: design/owbm_core.sv
`timescale 1ns / 1ps
// Slot sequencer: phase state machine, tick counter, bit shifters, presence latch.
// Depends on owbm_pkg for the phase enum, op codes, beat structs and phase_length.
module owbm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  owbm_pkg::t_cmd_beat i_beat,
    input  owbm_pkg::t_cfg      i_cfg,
    output owbm_pkg::t_res_beat o_res
);

    localparam logic [owbm_pkg::CNT_W-1:0]     CNT_TOP  = '1;
    localparam logic [owbm_pkg::BIT_IDX_W-1:0] LAST_BIT =
        owbm_pkg::BIT_IDX_W'(owbm_pkg::BITS_PER_BYTE - 1);

    owbm_pkg::t_phase                  r_phase, n_phase, w_cur;
    logic [owbm_pkg::CNT_W-1:0]        r_tick, n_tick, w_inc;
    logic [owbm_pkg::BIT_IDX_W-1:0]    r_bit, n_bit;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] r_send, n_send;
    logic [owbm_pkg::BITS_PER_BYTE-1:0] r_recv, n_recv;
    logic                              r_pres, n_pres;
    logic                              w_last_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= owbm_pkg::PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_send  <= '0;
            r_recv  <= '0;
            r_pres  <= 1'b1;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_send  <= n_send;
            r_recv  <= n_recv;
            r_pres  <= n_pres;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_send  = r_send;
        n_recv  = r_recv;
        n_pres  = r_pres;
        o_res   = '0;

        // start a command
        if (r_phase == owbm_pkg::PH_IDLE && i_beat.command_valid) begin
            case (i_beat.operation)
                owbm_pkg::OP_RESET: begin
                    n_tick  = '0;
                    n_bit   = '0;
                    n_phase = owbm_pkg::PH_RST_LOW;
                end
                owbm_pkg::OP_WRITE: begin
                    n_tick  = '0;
                    n_bit   = '0;
                    n_send  = i_beat.write_data;
                    n_phase = owbm_pkg::PH_WR_LEAD;
                end
                owbm_pkg::OP_READ: begin
                    n_tick  = '0;
                    n_bit   = '0;
                    n_recv  = '0;
                    n_phase = owbm_pkg::PH_RD_LEAD;
                end
                default: begin
                end
            endcase
        end

        w_cur      = n_phase;
        w_inc      = (n_tick == CNT_TOP) ? n_tick : n_tick + 1'b1;
        w_last_bit = (n_bit == LAST_BIT);

        if (w_cur != owbm_pkg::PH_IDLE) begin
            o_res.busy_res = 1'b1;
            case (w_cur)
                owbm_pkg::PH_RST_LOW,
                owbm_pkg::PH_WR_LEAD,
                owbm_pkg::PH_RD_LEAD: o_res.drive_low = 1'b1;
                owbm_pkg::PH_WR_HOLD: o_res.drive_low = !n_send[0];
                default:              o_res.drive_low = 1'b0;
            endcase

            if (w_inc >= owbm_pkg::phase_length(w_cur, i_cfg)) begin
                n_tick = '0;
                case (w_cur)
                    owbm_pkg::PH_RST_LOW:  n_phase = owbm_pkg::PH_RST_WAIT;
                    owbm_pkg::PH_RST_WAIT: begin
                        n_pres  = i_beat.line_level;
                        n_phase = owbm_pkg::PH_RST_TAIL;
                    end
                    owbm_pkg::PH_WR_LEAD:  n_phase = owbm_pkg::PH_WR_HOLD;
                    owbm_pkg::PH_RD_LEAD:  n_phase = owbm_pkg::PH_RD_WAIT;
                    owbm_pkg::PH_RD_WAIT: begin
                        if (i_beat.line_level) begin
                            n_recv[n_bit] = 1'b1;
                        end
                        n_phase = owbm_pkg::PH_RD_TAIL;
                    end
                    owbm_pkg::PH_WR_HOLD,
                    owbm_pkg::PH_RD_TAIL: begin
                        if (w_last_bit) begin
                            n_phase        = owbm_pkg::PH_IDLE;
                            o_res.done_res = 1'b1;
                        end else begin
                            n_bit   = n_bit + 1'b1;
                            n_send  = n_send >> 1;
                            n_phase = (w_cur == owbm_pkg::PH_WR_HOLD) ?
                                      owbm_pkg::PH_WR_LEAD : owbm_pkg::PH_RD_LEAD;
                        end
                    end
                    default: begin
                        n_phase        = owbm_pkg::PH_IDLE;
                        o_res.done_res = 1'b1;
                    end
                endcase
            end else begin
                n_tick = w_inc;
            end
        end

        o_res.read_data      = n_recv;
        o_res.presence_level = n_pres;
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.done_res) |=> (r_phase == owbm_pkg::PH_IDLE))
        else $error("phase not idle after done beat");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == owbm_pkg::PH_IDLE) |-> (r_tick == '0))
        else $error("tick counter nonzero while idle");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == owbm_pkg::PH_IDLE && !i_beat.command_valid)
        |=> (r_phase == owbm_pkg::PH_IDLE))
        else $error("left idle without a command");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.drive_low) |-> o_res.busy_res)
        else $error("bus driven low while not busy");

endmodule

FILE: design/one_wire_bus_master.sv
`timescale 1ns / 1ps
// One-wire bus master top level: command register, slot sequencer, result register.
// The command register takes an accepted command beat; the result register then loads its result.
// Throughput: one command beat per cycle when not stalled; the sequencer state updates every beat.
// Stall: a held result beat holds the sequencer, the result register and a full command register.
// Reset: synchronous active-low i_rst_n clears both pipeline valids, sets the
// sequencer idle with presence 1, and loads the timing registers' defaults.
module one_wire_bus_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    owbm_cmd_if.sink                        i_cmd,
    owbm_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owbm_pkg::ADDR_W-1:0]     paddr,
    input  logic [owbm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [owbm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    owbm_pkg::t_cfg      w_cfg;
    owbm_pkg::t_res_beat w_res;
    owbm_pkg::t_cmd_beat r_in_beat;
    owbm_pkg::t_res_beat r_out_beat;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                w_out_ready;
    logic                w_in_ready;
    logic                w_step;

    assign w_out_ready = !r_out_valid || o_res.ready;
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign w_step      = r_in_valid && w_out_ready;
    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_beat;

    owbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    owbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step),
        .i_beat  (r_in_beat),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_cmd.valid) begin
            r_in_beat <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_beat <= w_res;
        end
    end

endmodule
